>>> design/i2ctbd_pkg.sv
// ----------------------------------------------------------------------------
// i2ctbd_pkg
// Types, codes and constants shared by the I2C target bus decoder.
// ----------------------------------------------------------------------------
package i2ctbd_pkg;

  localparam int NUM_TARGETS   = 4;
  localparam int ADDR_W        = 7;
  localparam int MASK_W        = 4;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 7;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ADDR_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDR_ENABLE   = 3'd4;

  // bus event codes
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_ACCESS_START = 3'd1;
  localparam logic [2:0] EV_READ_TAKEN   = 3'd2;
  localparam logic [2:0] EV_WRITE_BYTE   = 3'd3;
  localparam logic [2:0] EV_STOP         = 3'd4;
  localparam logic [2:0] EV_RESTART      = 3'd5;
  localparam logic [2:0] EV_RESET_END    = 3'd6;

  localparam logic [3:0] BYTE_BITS    = 4'd8;
  localparam logic [7:0] NO_DATA_BYTE = 8'hff;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ADDR      = 3'd1,
    PH_GOTADDR   = 3'd2,
    PH_GOTDATA   = 3'd3,
    PH_SENDACK   = 3'd4,
    PH_DATA      = 3'd5,
    PH_SENTDATA  = 3'd6,
    PH_GOTACKNAK = 3'd7
  } phase_t;

  typedef logic [NUM_TARGETS-1:0][ADDR_W-1:0] addr_table_t;

  typedef struct packed {
    logic       scl_in;
    logic       sda_in;
    logic [7:0] dev_read_data;
    logic       dev_read_ok;
    logic       dev_write_ack;
  } in_item_t;

  typedef struct packed {
    logic       sda_release;
    logic       scl_release;
    logic [2:0] bus_event;
    logic [7:0] event_byte;
    logic [1:0] target_index;
    logic       is_read;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
    logic       last_scl;
    logic       last_sda;
    logic       read_dir;
    logic       send_ack;
    logic       selected;
    logic [1:0] matched_index;
    logic       reset_pending;
  } bus_state_t;

  localparam bus_state_t STATE_RESET = '{
    phase:         PH_IDLE,
    bit_count:     4'd0,
    shift_byte:    8'd0,
    last_scl:      1'b1,
    last_sda:      1'b1,
    read_dir:      1'b0,
    send_ack:      1'b1,
    selected:      1'b0,
    matched_index: 2'd0,
    reset_pending: 1'b1
  };

endpackage

>>> design/i2ctbd_step.sv
// ----------------------------------------------------------------------------
// i2ctbd_step
// Next-state and result logic for one sample of the SCL and SDA lines.
// ----------------------------------------------------------------------------
module i2ctbd_step (
  input  i2ctbd_pkg::bus_state_t              st,
  input  i2ctbd_pkg::in_item_t                item,
  input  i2ctbd_pkg::addr_table_t             target_addr,
  input  logic [i2ctbd_pkg::MASK_W-1:0]       addr_enable_mask,
  output i2ctbd_pkg::bus_state_t              st_next,
  output i2ctbd_pkg::out_item_t               result
);

  logic       rise_scl;
  logic       fall_scl;
  logic       start_det;
  logic       stop_cond;
  logic [7:0] dev_byte;
  logic [7:0] shifted_in;
  logic [3:0] count_inc;
  logic       hit;
  logic [1:0] hit_idx;
  logic       sda_out;
  logic [2:0] ev;
  logic [7:0] ev_byte;

  assign rise_scl   = !st.last_scl && item.scl_in;
  assign fall_scl   = st.last_scl && !item.scl_in;
  assign start_det  = item.scl_in && st.last_sda && !item.sda_in;
  assign stop_cond  = item.scl_in && !st.last_sda && item.sda_in;
  assign dev_byte   = item.dev_read_ok ? item.dev_read_data : i2ctbd_pkg::NO_DATA_BYTE;
  assign shifted_in = {st.shift_byte[6:0], item.sda_in};
  assign count_inc  = st.bit_count + 4'd1;

  // lowest-index enabled matching address wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = 2'd0;
    for (int i = 0; i < i2ctbd_pkg::NUM_TARGETS; i++) begin
      if (!hit && addr_enable_mask[i] && target_addr[i] == shifted_in[7:1]) begin
        hit     = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  always_comb begin
    st_next = st;
    sda_out = 1'b1;
    ev      = i2ctbd_pkg::EV_NONE;
    ev_byte = 8'd0;

    if (st.reset_pending) begin
      st_next.reset_pending = 1'b0;
      ev                    = i2ctbd_pkg::EV_RESET_END;
    end

    case (st.phase)
      i2ctbd_pkg::PH_IDLE: begin
        if (start_det) begin
          st_next.phase     = i2ctbd_pkg::PH_ADDR;
          st_next.bit_count = 4'd0;
        end
      end
      i2ctbd_pkg::PH_ADDR: begin
        if (rise_scl) begin
          st_next.shift_byte = shifted_in;
          st_next.bit_count  = count_inc;
          if (count_inc >= i2ctbd_pkg::BYTE_BITS) begin
            st_next.read_dir = shifted_in[0];
            if (hit) begin
              st_next.selected      = 1'b1;
              st_next.matched_index = hit_idx;
              ev                    = i2ctbd_pkg::EV_ACCESS_START;
              if (shifted_in[0]) begin
                st_next.shift_byte = dev_byte;
              end
              st_next.send_ack = 1'b1;
            end else begin
              st_next.selected = 1'b0;
              st_next.send_ack = 1'b0;
            end
            st_next.bit_count = 4'd0;
            st_next.phase     = i2ctbd_pkg::PH_GOTADDR;
          end
        end
      end
      i2ctbd_pkg::PH_GOTADDR, i2ctbd_pkg::PH_GOTDATA: begin
        if (fall_scl) begin
          sda_out       = !st.send_ack;
          st_next.phase = i2ctbd_pkg::PH_SENDACK;
        end
      end
      i2ctbd_pkg::PH_SENDACK: begin
        sda_out = !st.send_ack;
        if (fall_scl) begin
          st_next.phase = i2ctbd_pkg::PH_DATA;
        end
      end
      i2ctbd_pkg::PH_SENTDATA: begin
        if (rise_scl) begin
          // controller ack pulls the next byte from the device
          if (!item.sda_in) begin
            st_next.shift_byte = dev_byte;
            ev                 = i2ctbd_pkg::EV_READ_TAKEN;
          end
          st_next.bit_count = 4'd0;
          st_next.phase     = i2ctbd_pkg::PH_GOTACKNAK;
        end
      end
      i2ctbd_pkg::PH_GOTACKNAK: begin
        if (fall_scl) begin
          st_next.phase = i2ctbd_pkg::PH_DATA;
        end
      end
      i2ctbd_pkg::PH_DATA: begin
        if (stop_cond) begin
          if (st.selected) begin
            ev = i2ctbd_pkg::EV_STOP;
          end
          st_next.selected = 1'b0;
          st_next.phase    = i2ctbd_pkg::PH_IDLE;
        end else if (start_det) begin
          if (st.selected) begin
            ev = i2ctbd_pkg::EV_RESTART;
          end
          st_next.selected  = 1'b0;
          st_next.phase     = i2ctbd_pkg::PH_ADDR;
          st_next.bit_count = 4'd0;
        end else if (st.selected) begin
          if (st.read_dir) begin
            sda_out = st.shift_byte[7];
            if (fall_scl) begin
              st_next.shift_byte = {st.shift_byte[6:0], 1'b1};
              st_next.bit_count  = count_inc;
              if (count_inc >= i2ctbd_pkg::BYTE_BITS) begin
                st_next.phase = i2ctbd_pkg::PH_SENTDATA;
              end
            end
          end else if (rise_scl) begin
            st_next.shift_byte = shifted_in;
            st_next.bit_count  = count_inc;
            if (count_inc >= i2ctbd_pkg::BYTE_BITS) begin
              st_next.send_ack  = item.dev_write_ack;
              ev                = i2ctbd_pkg::EV_WRITE_BYTE;
              ev_byte           = shifted_in;
              st_next.bit_count = 4'd0;
              st_next.phase     = i2ctbd_pkg::PH_GOTDATA;
            end
          end
        end
      end
      default: begin
        st_next.phase = i2ctbd_pkg::PH_IDLE;
      end
    endcase

    st_next.last_scl = item.scl_in;
    st_next.last_sda = item.sda_in;
  end

  always_comb begin
    result.sda_release  = sda_out;
    result.scl_release  = 1'b1;
    result.bus_event    = ev;
    result.event_byte   = ev_byte;
    result.target_index = st_next.matched_index;
    result.is_read      = st_next.read_dir;
  end

endmodule

>>> design/i2c_target_bus_decoder_unit.sv
// ----------------------------------------------------------------------------
// i2c_target_bus_decoder_unit
// I2C target bus decoder with 7-bit addressing and four target addresses.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (one line sample)
// out      output     out_valid / out_ready  out_data  (one result per sample)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// one sample per cycle while out_ready stays high; a taken request passes through the
// input register, then the result register holding the decoded step
// in_ready falls only while both registers are full and out_ready is low
// synchronous reset returns all bus state to idle; the first result after
// reset carries the reset-end event
// ----------------------------------------------------------------------------
module i2c_target_bus_decoder_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  i2ctbd_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output i2ctbd_pkg::out_item_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [i2ctbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [i2ctbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  i2ctbd_pkg::addr_table_t        target_addr;
  logic [i2ctbd_pkg::MASK_W-1:0]  addr_enable_mask;
  i2ctbd_pkg::bus_state_t         bus_state;
  i2ctbd_pkg::bus_state_t         bus_state_next;
  i2ctbd_pkg::in_item_t           in_hold;
  logic                           in_hold_valid;
  i2ctbd_pkg::out_item_t          step_result;
  logic                           advance;

  assign advance  = in_hold_valid && (!out_valid || out_ready);
  assign in_ready = !in_hold_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_addr      <= '0;
      addr_enable_mask <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < i2ctbd_pkg::NUM_TARGETS; i++) begin
        if (cfg_index == i2ctbd_pkg::REG_TARGET_ADDR_0 + i2ctbd_pkg::CFG_INDEX_W'(i)) begin
          target_addr[i] <= cfg_data[i2ctbd_pkg::ADDR_W-1:0];
        end
      end
      if (cfg_index == i2ctbd_pkg::REG_ADDR_ENABLE) begin
        addr_enable_mask <= cfg_data[i2ctbd_pkg::MASK_W-1:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold_valid <= 1'b0;
    end else if (in_ready) begin
      in_hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_hold <= in_data;
    end
  end

  i2ctbd_step u_step (
    .st               (bus_state),
    .item             (in_hold),
    .target_addr      (target_addr),
    .addr_enable_mask (addr_enable_mask),
    .st_next          (bus_state_next),
    .result           (step_result)
  );

  // bus state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_state <= i2ctbd_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        bus_state <= bus_state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

>>> design/i2ctbd_checker.sv
// ----------------------------------------------------------------------------
// i2ctbd_checker
// Port-level checks on the I2C target bus decoder results.
// ----------------------------------------------------------------------------
module i2ctbd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input i2ctbd_pkg::out_item_t out_data
);

  logic first_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      first_seen <= 1'b1;
    end
  end

  // first result after reset reports reset end
  a_first_reset_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !first_seen |-> out_data.bus_event == i2ctbd_pkg::EV_RESET_END)
    else $error("first result lacks reset-end event");

  // reset end is reported only once
  a_single_reset_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_seen |-> out_data.bus_event != i2ctbd_pkg::EV_RESET_END)
    else $error("reset-end event repeated");

  // data byte only rides with a write byte event
  a_event_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bus_event != i2ctbd_pkg::EV_WRITE_BYTE
      |-> out_data.event_byte == 8'd0)
    else $error("event byte set without write event");

  a_scl_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.scl_release)
    else $error("scl stretched");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind i2c_target_bus_decoder_unit i2ctbd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
